// File: hdl/fpdf_pkg.sv
// ----------------------------------------------------------------------------
// fpdf_pkg
// Shared constants, types and helpers of the fixed-point decimal formatter.
// ----------------------------------------------------------------------------
package fpdf_pkg;

  localparam int MAX_FIELD_DEF = 12;

  // conversion stops after this many digits whatever the precision
  localparam logic [4:0] DIGIT_CAP = 5'd20;

  // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_A     = 8'h41;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic step;
    logic plan;
    logic emit;
  } fpdf_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic conv_done;
    logic zero_width;
    logic emit_last;
  } fpdf_stat_t;

  // characters of the overflow text
  function automatic logic [7:0] nan_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = CH_PLUS;
      2'd1:    ch = CH_N;
      2'd2:    ch = CH_A;
      default: ch = CH_N;
    endcase
    return ch;
  endfunction

endpackage

// File: hdl/fpdf_ctrl.sv
// ----------------------------------------------------------------------------
// fpdf_ctrl
// Sequencer of the formatter: load, digit conversion, layout, emission.
// ----------------------------------------------------------------------------
module fpdf_ctrl import fpdf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  fpdf_stat_t stat,
  output fpdf_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_PLAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (stat.conv_done) begin
          state_nxt = ST_PLAN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = stat.zero_width ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTHESIS
  a_start_enters_conv: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == ST_CONV)
    else $error("accepted word did not start conversion");
`endif

endmodule

// File: hdl/fpdf_datapath.sv
// ----------------------------------------------------------------------------
// fpdf_datapath
// Divide-by-ten digit extraction, digit store, field layout and character out.
// ----------------------------------------------------------------------------
module fpdf_datapath import fpdf_pkg::*; #(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fpdf_cmd_t          cmd,
  output fpdf_stat_t         stat,
  input  logic signed [31:0] in_value,
  input  logic        [3:0]  in_field_width,
  input  logic        [3:0]  in_precision,
  input  logic        [7:0]  in_pos_char,
  input  logic        [7:0]  in_neg_char,
  output logic               out_valid,
  output logic        [7:0]  out_char_out,
  output logic               out_last,
  output logic               out_overflow
);

  localparam int PW = $clog2(MAX_FIELD + 1);
  localparam int LW = ((PW > 5) ? PW : 5) + 1;

  logic [31:0]   mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic          left_r, left_nxt;
  logic [PW-1:0] width_r, width_nxt;
  logic [3:0]    prec_r, prec_nxt;
  logic [7:0]    possign_r, possign_nxt;
  logic [7:0]    negsign_r, negsign_nxt;
  logic [4:0]    n_r, n_nxt;
  logic [3:0]    dg_r [MAX_FIELD];
  logic [3:0]    dg_nxt [MAX_FIELD];
  logic          ovf_r, ovf_nxt;
  logic [PW-1:0] tstart_r, tstart_nxt;
  logic [4:0]    rem_r, rem_nxt;
  logic          pt_r, pt_nxt;
  logic [PW-1:0] col_r, col_nxt;

  logic          out_valid_r;
  logic [7:0]    out_char_r, out_char_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r;

  // one digit per step via reciprocal multiply
  logic [63:0]   prod;
  logic [28:0]   quot;
  logic [3:0]    ten_q_lo;
  logic [3:0]    digit;

  assign prod     = {32'd0, mag_r} * {32'd0, RECIP_10};
  assign quot     = prod[63:RECIP_SHIFT];
  assign ten_q_lo = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign digit    = mag_r[3:0] - ten_q_lo;

  // layout of the field once the digit count is known
  logic [LW-1:0] len_w, width_w, need_w;
  logic          fit_ovf;

  assign len_w   = LW'(n_r) + LW'(prec_r != 4'd0);
  assign width_w = LW'(width_r);
  assign need_w  = left_r ? (len_w + LW'(neg_r)) : (len_w + LW'(1));
  assign fit_ovf = (need_w > width_w);

  logic       in_text, at_point, last_col;
  logic [3:0] dig_top;

  assign dig_top  = dg_r[MAX_FIELD-1];
  assign in_text  = (col_r >= tstart_r) && (rem_r != 5'd0);
  assign at_point = pt_r && (rem_r == 5'(prec_r));
  assign last_col = (col_r == width_r - PW'(1));

  assign stat.conv_done  = !(((n_r < 5'(prec_r) + 5'd1) || (mag_r != 32'd0)) &&
                             (n_r < DIGIT_CAP));
  assign stat.zero_width = (width_r == '0);
  assign stat.emit_last  = last_col;

  always_comb begin
    mag_nxt      = mag_r;
    neg_nxt      = neg_r;
    left_nxt     = left_r;
    width_nxt    = width_r;
    prec_nxt     = prec_r;
    possign_nxt  = possign_r;
    negsign_nxt  = negsign_r;
    n_nxt        = n_r;
    dg_nxt       = dg_r;
    ovf_nxt      = ovf_r;
    tstart_nxt   = tstart_r;
    rem_nxt      = rem_r;
    pt_nxt       = pt_r;
    col_nxt      = col_r;
    out_char_nxt = CH_SPACE;
    out_last_nxt = last_col;

    if (cmd.load) begin
      neg_nxt     = in_value[31];
      mag_nxt     = in_value[31] ? (32'd0 - $unsigned(in_value)) : $unsigned(in_value);
      width_nxt   = (int'(in_field_width) > MAX_FIELD) ? PW'(MAX_FIELD)
                                                       : PW'(in_field_width);
      prec_nxt    = in_precision;
      left_nxt    = (in_pos_char == CH_SPACE);
      possign_nxt = in_pos_char;
      negsign_nxt = in_neg_char;
      n_nxt       = 5'd0;
    end

    // digits enter at the top and sink, so the leading digit ends on top
    if (cmd.step) begin
      mag_nxt = 32'(quot);
      n_nxt   = n_r + 5'd1;
      for (int i = 0; i < MAX_FIELD - 1; i++) begin
        dg_nxt[i] = dg_r[i+1];
      end
      dg_nxt[MAX_FIELD-1] = digit;
    end

    if (cmd.plan) begin
      ovf_nxt    = fit_ovf;
      tstart_nxt = left_r ? PW'(neg_r) : PW'(width_w - len_w);
      rem_nxt    = n_r;
      pt_nxt     = (prec_r != 4'd0);
      col_nxt    = '0;
    end

    if (cmd.emit) begin
      col_nxt = col_r + PW'(1);
      if (ovf_r) begin
        out_char_nxt = (LW'(col_r) < LW'(4)) ? nan_char(col_r[1:0]) : CH_SPACE;
      end else if ((col_r == '0) && (!left_r || neg_r)) begin
        out_char_nxt = neg_r ? negsign_r : possign_r;
      end else if (in_text) begin
        if (at_point) begin
          out_char_nxt = CH_POINT;
          pt_nxt       = 1'b0;
        end else begin
          out_char_nxt = CH_ZERO + {4'd0, dig_top};
          rem_nxt      = rem_r - 5'd1;
          for (int i = MAX_FIELD - 1; i > 0; i--) begin
            dg_nxt[i] = dg_r[i-1];
          end
          dg_nxt[0] = 4'd0;
        end
      end else begin
        out_char_nxt = CH_SPACE;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    left_r    <= left_nxt;
    width_r   <= width_nxt;
    prec_r    <= prec_nxt;
    possign_r <= possign_nxt;
    negsign_r <= negsign_nxt;
    n_r       <= n_nxt;
    dg_r      <= dg_nxt;
    ovf_r     <= ovf_nxt;
    tstart_r  <= tstart_nxt;
    rem_r     <= rem_nxt;
    pt_r      <= pt_nxt;
    col_r     <= col_nxt;
    if (cmd.emit) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
      out_ovf_r  <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

`ifndef SYNTHESIS
  a_field_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |=> out_valid_r && (out_ovf_r == $past(out_ovf_r)))
    else $error("field broken or overflow flag changed inside a field");

  a_digits_fit_store: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.plan && !fit_ovf |-> LW'(n_r) <= LW'(MAX_FIELD))
    else $error("fitting number has more digits than the store holds");

  a_text_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r && !out_ovf_r |-> (rem_r == 5'd0) && !pt_r)
    else $error("field ended before all digits were sent");
`endif

endmodule

// File: hdl/fixed_point_decimal_formatter_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter_unit
// Signed fixed-point value to a fixed-width ASCII decimal field.
// ----------------------------------------------------------------------------
// Usage: drive the in_ ports and pulse start while busy is low; the word is
// taken at that edge. The unit then extracts one decimal digit per cycle
// with a multiply-by-reciprocal divider, n = max(precision + 1, digit count
// of the magnitude) steps (at most 10 for precision up to 9), lays out the
// field in the plan state, and sends the field_width characters (clamped
// to MAX_FIELD) one per cycle, leftmost first.
// Each character is on out_char_out for exactly one cycle with out_valid
// high; out_last marks the final one, out_overflow is high on every
// character of a "+NAN" field. The receiver cannot stall the stream.
// The first strobe follows the conversion steps, the plan state and the
// first emit state, whose character is registered into out_char_out.
// One word is handled at a time: a new one is taken only once busy is low,
// so the word rate is set by the single divide-by-ten step and the output.
// A field width of zero produces no characters. Reset (rst_n low,
// synchronous) returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
module fixed_point_decimal_formatter_unit import fpdf_pkg::*; #(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_value,
  input  logic        [3:0]  in_field_width,
  input  logic        [3:0]  in_precision,
  input  logic        [7:0]  in_pos_char,
  input  logic        [7:0]  in_neg_char,
  output logic               out_valid,
  output logic        [7:0]  out_char_out,
  output logic               out_last,
  output logic               out_overflow
);

  fpdf_cmd_t  cmd;
  fpdf_stat_t stat;

  fpdf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  fpdf_datapath #(
    .MAX_FIELD (MAX_FIELD)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_value       (in_value),
    .in_field_width (in_field_width),
    .in_precision   (in_precision),
    .in_pos_char    (in_pos_char),
    .in_neg_char    (in_neg_char),
    .out_valid      (out_valid),
    .out_char_out   (out_char_out),
    .out_last       (out_last),
    .out_overflow   (out_overflow)
  );

endmodule
